/* src/sddw_pkg.sv */
// ----------------------------------------------------------------------------
// sddw_pkg
// shared types and constants of the signed decimal digit writer
// ----------------------------------------------------------------------------
package sddw_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int POS_W       = $clog2(DIGIT_COUNT);
    localparam int VALUE_W     = 28;
    localparam int MAG_W       = 27;
    localparam int ADDR_W      = 4;
    localparam int CODE_W      = 4;

    localparam logic [VALUE_W-1:0] POS_LIMIT  = 28'd99999999;
    localparam logic [VALUE_W-1:0] NEG_LIMIT  = 28'd9999999;
    localparam logic [31:0]        RECIP_TEN  = 32'hCCCCCCCD;
    localparam int                 RECIP_SH   = 35;

    localparam logic [CODE_W-1:0]  CODE_ZERO  = 4'd0;
    localparam logic [CODE_W-1:0]  CODE_DASH  = 4'd10;
    localparam logic [CODE_W-1:0]  CODE_BLANK = 4'd15;
    localparam logic [ADDR_W-1:0]  ADDR_NONE  = 4'd0;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic last_beat;
    } sts_t;

endpackage

/* src/sddw_ctrl.sv */
// ----------------------------------------------------------------------------
// sddw_ctrl
// handshake controller: takes an item, then steps out its digit writes
// ----------------------------------------------------------------------------
module sddw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  sddw_pkg::sts_t sts,
    output sddw_pkg::cmd_t cmd
);

    sddw_pkg::state_t state_reg;
    sddw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sddw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        result_valid = 1'b0;
        item_ready   = 1'b0;
        unique case (state_reg)
            sddw_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = sddw_pkg::ST_EMIT;
                end
            end
            sddw_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                // next item may enter on the final write
                item_ready   = sts.last_beat && result_ready;
                if (sts.last_beat && result_ready && !item_valid)
                begin
                    state_next = sddw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sddw_pkg::ST_IDLE;
            end
        endcase
        cmd.load    = item_valid && item_ready;
        cmd.advance = result_valid && result_ready;
    end

endmodule

/* src/sddw_datapath.sv */
// ----------------------------------------------------------------------------
// sddw_datapath
// magnitude register with a divide-by-ten step and digit code selection
// ----------------------------------------------------------------------------
module sddw_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sddw_pkg::cmd_t                        cmd,
    output sddw_pkg::sts_t                        sts,
    input  logic signed [sddw_pkg::VALUE_W-1:0]   value,
    output logic        [sddw_pkg::ADDR_W-1:0]    digit_address,
    output logic        [sddw_pkg::CODE_W-1:0]    digit_code,
    output logic                                  last,
    output logic                                  overflow
);

    localparam int PROD_W = sddw_pkg::RECIP_SH + sddw_pkg::MAG_W;

    logic [sddw_pkg::MAG_W-1:0]   mag_reg;
    logic                         neg_reg;
    logic                         ovf_reg;
    logic                         dash_reg;
    logic [sddw_pkg::POS_W-1:0]   pos_reg;

    logic                         in_neg;
    logic [sddw_pkg::VALUE_W-1:0] in_mag;
    logic                         in_ovf;
    logic [PROD_W-1:0]            prod;
    logic [sddw_pkg::MAG_W-1:0]   quo;
    logic [sddw_pkg::MAG_W-1:0]   quo_ten;
    logic [sddw_pkg::CODE_W-1:0]  rem;
    logic                         show_digit;
    logic                         show_dash;
    logic                         at_end;
    logic [sddw_pkg::CODE_W-1:0]  code;

    always_comb
    begin
        in_neg = value[sddw_pkg::VALUE_W-1];
        in_mag = in_neg ? (~value + 1'b1) : value;
        in_ovf = in_neg ? (in_mag > sddw_pkg::NEG_LIMIT) : (in_mag > sddw_pkg::POS_LIMIT);
    end

    // divide by ten through the reciprocal, exact below 2**32
    always_comb
    begin
        prod    = PROD_W'(mag_reg) * PROD_W'(sddw_pkg::RECIP_TEN);
        quo     = prod[sddw_pkg::RECIP_SH +: sddw_pkg::MAG_W];
        quo_ten = (quo << 3) + (quo << 1);
        rem     = sddw_pkg::CODE_W'(mag_reg - quo_ten);
    end

    always_comb
    begin
        at_end     = (pos_reg == sddw_pkg::POS_W'(sddw_pkg::DIGIT_COUNT - 1));
        show_digit = (mag_reg != '0) || (pos_reg == '0);
        show_dash  = !show_digit && neg_reg && !dash_reg;
        if (show_digit)
        begin
            code = rem;
        end
        else if (show_dash)
        begin
            code = sddw_pkg::CODE_DASH;
        end
        else
        begin
            code = sddw_pkg::CODE_BLANK;
        end
        digit_address = ovf_reg ? sddw_pkg::ADDR_NONE
                                : sddw_pkg::ADDR_W'(pos_reg) + 1'b1;
        digit_code    = ovf_reg ? sddw_pkg::CODE_ZERO : code;
        last          = ovf_reg || at_end;
        overflow      = ovf_reg;
        sts.last_beat = ovf_reg || at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            dash_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            pos_reg  <= '0;
            dash_reg <= 1'b0;
            ovf_reg  <= in_ovf;
        end
        else if (cmd.advance)
        begin
            pos_reg  <= pos_reg + 1'b1;
            dash_reg <= dash_reg || show_dash;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= in_mag[sddw_pkg::MAG_W-1:0];
            neg_reg <= in_neg;
        end
        else if (cmd.advance)
        begin
            mag_reg <= quo;
        end
    end

endmodule

/* src/signed_decimal_digit_writer_top.sv */
// ----------------------------------------------------------------------------
// signed_decimal_digit_writer_top
// turns one signed value into the digit-register writes of a code b display
// ----------------------------------------------------------------------------
// usage:
//   item channel: value with item_valid / item_ready
//   result channel: digit_address, digit_code, last, overflow with
//   result_valid / result_ready, one digit-register write per transfer
// each item gives eight writes, least significant digit at address 1,
// digits then a dash when negative then blanks; last marks address 8
// a value out of range gives one write with overflow set and address 0
// the first write is shown the cycle after the item is taken
// throughput: one write per cycle while the receiver is ready, one digit
// per divide-by-ten step of the magnitude register; the next item is taken
// on the final write
// a stalled receiver holds the current write and freezes the digit loop
// reset clears the controller to idle with no write pending
// ----------------------------------------------------------------------------
module signed_decimal_digit_writer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [sddw_pkg::VALUE_W-1:0] value,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic        [sddw_pkg::ADDR_W-1:0]  digit_address,
    output logic        [sddw_pkg::CODE_W-1:0]  digit_code,
    output logic                                last,
    output logic                                overflow
);

    sddw_pkg::cmd_t cmd;
    sddw_pkg::sts_t sts;

    sddw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    sddw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value         (value),
        .digit_address (digit_address),
        .digit_code    (digit_code),
        .last          (last),
        .overflow      (overflow)
    );

    a_item_starts_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> result_valid)
        else $error("no write after item taken");

    a_overflow_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> (digit_address == sddw_pkg::ADDR_NONE && last))
        else $error("overflow write carries an address");

    a_address_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last) |=>
        (result_valid && digit_address == 4'($past(digit_address) + 4'd1)))
        else $error("digit address did not step");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> !item_ready)
        else $error("item taken mid sequence");

endmodule
